[rtl/core/twp_pkg.sv]
`default_nettype none

package twp_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int PHASE_BITS_DEF  = 16;

  localparam int CORDIC_STAGES = 30;
  localparam int ANGLE_BITS    = 32;
  localparam int FRAC_SHIFT    = 20;
  localparam int SQRT3_Q20     = 1816187;
  // datapath headroom over the sample width: Q20 scale, sqrt(3), CORDIC gain, sign
  localparam int XY_GUARD      = 25;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic both_zero;
    logic turned;
  } twp_class_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ANGLE_BITS-1:0] atan_turn(input int idx);
    logic [ANGLE_BITS-1:0] t;
    case (idx)
      0:       t = 32'h2000_0000;
      1:       t = 32'h12E4_051E;
      2:       t = 32'h09FB_385B;
      3:       t = 32'h0511_11D4;
      4:       t = 32'h028B_0D43;
      5:       t = 32'h0145_D7E1;
      6:       t = 32'h00A2_F61E;
      7:       t = 32'h0051_7C55;
      8:       t = 32'h0028_BE53;
      9:       t = 32'h0014_5F2F;
      10:      t = 32'h000A_2F98;
      11:      t = 32'h0005_17CC;
      12:      t = 32'h0002_8BE6;
      13:      t = 32'h0001_45F3;
      14:      t = 32'h0000_A2F9;
      15:      t = 32'h0000_517C;
      16:      t = 32'h0000_28BE;
      17:      t = 32'h0000_145F;
      18:      t = 32'h0000_0A2F;
      19:      t = 32'h0000_0517;
      20:      t = 32'h0000_028B;
      21:      t = 32'h0000_0145;
      22:      t = 32'h0000_00A2;
      23:      t = 32'h0000_0051;
      24:      t = 32'h0000_0028;
      25:      t = 32'h0000_0014;
      26:      t = 32'h0000_000A;
      27:      t = 32'h0000_0005;
      28:      t = 32'h0000_0002;
      29:      t = 32'h0000_0001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/core/twp_fifo.sv]
`default_nettype none

module twp_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = twp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/twp_front.sv]
`default_nettype none

module twp_front #(
  parameter int SAMPLE_BITS = twp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0]             sample_first,
  input  wire logic [SAMPLE_BITS-1:0]             sample_second,
  input  wire logic [SAMPLE_BITS-1:0]             sample_third,
  output logic signed [SAMPLE_BITS+twp_pkg::XY_GUARD-1:0] vec_x,
  output logic signed [SAMPLE_BITS+twp_pkg::XY_GUARD-1:0] vec_y,
  output twp_pkg::twp_class_t                     cls
);

  localparam int XY_BITS = SAMPLE_BITS + twp_pkg::XY_GUARD;
  localparam logic signed [22:0] SQRT3_C = 23'(twp_pkg::SQRT3_Q20);

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS+1:0] den;
  logic signed [XY_BITS-1:0]     y0;
  logic signed [XY_BITS-1:0]     x0;

  assign diff = $signed({1'b0, sample_first}) - $signed({1'b0, sample_third});
  assign den  = $signed({1'b0, sample_second, 1'b0})
              - $signed({2'b00, sample_first})
              - $signed({2'b00, sample_third});

  assign y0 = XY_BITS'(diff) * XY_BITS'(SQRT3_C);
  assign x0 = XY_BITS'(den) <<< twp_pkg::FRAC_SHIFT;

  // left half-plane: turn by half a turn so the CORDIC sees x >= 0
  assign cls = '{both_zero: (diff == '0) && (den == '0),
                 turned:    den[SAMPLE_BITS+1]};
  assign vec_x = cls.turned ? -x0 : x0;
  assign vec_y = cls.turned ? -y0 : y0;

endmodule

`default_nettype wire

[rtl/core/twp_back.sv]
`default_nettype none

module twp_back #(
  parameter int SAMPLE_BITS = twp_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = twp_pkg::PHASE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic signed [SAMPLE_BITS+twp_pkg::XY_GUARD-1:0] in_x,
  input  wire logic signed [SAMPLE_BITS+twp_pkg::XY_GUARD-1:0] in_y,
  input  wire twp_pkg::twp_class_t               in_cls,
  output logic                                   in_pop,
  input  wire logic                              out_full,
  output logic                                   out_push,
  output logic [PHASE_BITS-1:0]                  out_phase
);

  localparam int XY_BITS = SAMPLE_BITS + twp_pkg::XY_GUARD;
  localparam int STAGES  = twp_pkg::CORDIC_STAGES;
  localparam int ABITS   = twp_pkg::ANGLE_BITS;
  localparam logic [ABITS-1:0] ROUND_HALF = ABITS'(1) << (ABITS - 1 - PHASE_BITS);

  logic signed [XY_BITS-1:0] sx   [STAGES+1];
  logic signed [XY_BITS-1:0] sy   [STAGES+1];
  logic [ABITS-1:0]          sacc [STAGES+1];
  logic [STAGES:0]           szero;
  logic [STAGES:0]           sval;
  logic                      en;
  logic [ABITS-1:0]          rounded;

  assign en       = !sval[STAGES] || !out_full;
  assign in_pop   = en && in_valid;
  assign out_push = sval[STAGES] && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sval <= '0;
    end else if (en) begin
      sval <= {sval[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]    <= in_x;
      sy[0]    <= in_y;
      sacc[0]  <= in_cls.turned ? twp_pkg::HALF_TURN : '0;
      szero[0] <= in_cls.both_zero;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                      neg;
    logic signed [XY_BITS-1:0] ymag;
    logic signed [XY_BITS-1:0] xs;
    logic signed [XY_BITS-1:0] ys;
    logic [ABITS-1:0]          step;

    assign neg  = sy[k][XY_BITS-1];
    assign ymag = neg ? -sy[k] : sy[k];
    assign xs   = sx[k] >>> k;
    assign ys   = ymag >>> k;
    assign step = twp_pkg::atan_turn(k);

    always_ff @(posedge clk) begin
      if (en) begin
        sx[k+1]    <= sx[k] + ys;
        sy[k+1]    <= neg ? sy[k] + xs : sy[k] - xs;
        sacc[k+1]  <= neg ? sacc[k] - step : sacc[k] + step;
        szero[k+1] <= szero[k];
      end
    end
  end

  assign rounded   = sacc[STAGES] + ROUND_HALF;
  assign out_phase = szero[STAGES] ? '0 : rounded[ABITS-1 -: PHASE_BITS];

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (sval[STAGES] && out_full) |=> (sval[STAGES] && $stable(sacc[STAGES])))
    else $error("result moved while output stalled");

  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    sval[STAGES] |-> !sx[STAGES][XY_BITS-1])
    else $error("CORDIC x went negative");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && sval[STAGES-1]) |=> sval[STAGES])
    else $error("request lost in pipeline");

endmodule

`default_nettype wire

[rtl/core/three_step_wrapped_phase.sv]
`default_nettype none

// Wrapped phase from three fringe samples shifted by a third of a turn.
// Input channel: drive sample_first/second/third and raise push; a request is
// taken on a rising edge with push high and full low.
// Output channel: wrapped_phase holds the oldest result while empty is low; it
// is taken on a rising edge with pop high. The phase is a binary angle, one
// full turn = 2^PHASE_BITS; both difference terms zero gives 0.
// Path from the accepting edge to empty going low when the output is drained:
// the input queue is written at the accepting edge, then one load stage, 30
// CORDIC stages and one output slot follow.
// Throughput: one request per cycle unless stalled (unrolled 30-stage CORDIC).
// When the receiver stalls, the CORDIC pipeline freezes as a whole once its
// last stage holds a result that the output queue cannot take; the input queue
// then fills and full rises. No request is dropped.
// Reset (rst, synchronous) empties both queues and the pipeline; full and
// empty read low/high in the cycle after it.
module three_step_wrapped_phase #(
  parameter int SAMPLE_BITS = twp_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = twp_pkg::PHASE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] sample_first,
  input  wire logic [SAMPLE_BITS-1:0] sample_second,
  input  wire logic [SAMPLE_BITS-1:0] sample_third,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [PHASE_BITS-1:0]       wrapped_phase
);

  localparam int XY_BITS  = SAMPLE_BITS + twp_pkg::XY_GUARD;
  localparam int CLS_BITS = $bits(twp_pkg::twp_class_t);
  localparam int Q_BITS   = CLS_BITS + 2 * XY_BITS;

  logic signed [XY_BITS-1:0] f_x;
  logic signed [XY_BITS-1:0] f_y;
  twp_pkg::twp_class_t       f_cls;
  logic [Q_BITS-1:0]         q_rd;
  logic                      q_empty;
  logic                      q_pop;
  logic signed [XY_BITS-1:0] b_x;
  logic signed [XY_BITS-1:0] b_y;
  twp_pkg::twp_class_t       b_cls;
  logic                      o_full;
  logic                      o_push;
  logic [PHASE_BITS-1:0]     o_phase;

  twp_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .sample_first (sample_first),
    .sample_second(sample_second),
    .sample_third (sample_third),
    .vec_x        (f_x),
    .vec_y        (f_y),
    .cls          (f_cls)
  );

  twp_fifo #(
    .WIDTH(Q_BITS),
    .DEPTH(twp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data({f_cls, f_x, f_y}),
    .full   (full),
    .pop    (q_pop),
    .rd_data(q_rd),
    .empty  (q_empty)
  );

  assign b_cls = q_rd[Q_BITS-1 -: CLS_BITS];
  assign b_x   = q_rd[2*XY_BITS-1 -: XY_BITS];
  assign b_y   = q_rd[XY_BITS-1:0];

  twp_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_x     (b_x),
    .in_y     (b_y),
    .in_cls   (b_cls),
    .in_pop   (q_pop),
    .out_full (o_full),
    .out_push (o_push),
    .out_phase(o_phase)
  );

  twp_fifo #(
    .WIDTH(PHASE_BITS),
    .DEPTH(twp_pkg::QUEUE_DEPTH)
  ) u_result (
    .clk    (clk),
    .rst    (rst),
    .push   (o_push),
    .wr_data(o_phase),
    .full   (o_full),
    .pop    (pop),
    .rd_data(wrapped_phase),
    .empty  (empty)
  );

endmodule

`default_nettype wire
